// File: rtl/asfc_pkg.sv
package asfc_pkg;

    // format_mode codes
    localparam logic [1:0] MODE_MULAW = 2'd0;
    localparam logic [1:0] MODE_EIGHT = 2'd1;
    localparam logic [1:0] MODE_PASS  = 2'd2;

    // direction codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORMAT_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTION   = 2'd1;

    // mu-law constants
    localparam logic [12:0] MU_MAX       = 13'h1FFF;
    localparam logic [14:0] MU_BIAS      = 15'd33;
    localparam logic [7:0]  MU_ZERO_TRAP = 8'h02;
    localparam logic [7:0]  MU_DEC_BIAS  = 8'h84;

    localparam logic [7:0]  EIGHT_FLIP   = 8'h80;
    localparam logic [15:0] EIGHT_OFFSET = 16'd32640;

    typedef struct packed {
        logic signed [15:0] linear_in;
        logic [7:0]         code_in;
        logic               block_end;
    } req_t;

    typedef struct packed {
        logic [7:0]         code_out;
        logic signed [15:0] linear_out;
        logic               block_end_out;
    } result_t;

endpackage

// File: rtl/audio_sample_format_codec.sv
// channel   direction  handshake                 payload
// request   in         start, busy               item (req_t)
// result    out        done (one-cycle strobe)   result (result_t)
// config    in         cfg_valid, cfg_ready      cfg_index, cfg_data
//
// One request per cycle; busy never rises. Result appears on done once
// the request has passed one input register and one result register.
// Async active-low reset clears the pipeline valids and the config
// (mu-law, encode). The result side cannot stall, so nothing backs up.
module audio_sample_format_codec (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  asfc_pkg::req_t                   item,
    output logic                             done,
    output asfc_pkg::result_t                result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [asfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [asfc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic              in_valid_reg;
    asfc_pkg::req_t    in_item_reg;
    logic              done_reg;
    asfc_pkg::result_t result_reg;
    asfc_pkg::result_t result_next;
    logic [1:0]        format_mode_reg;
    logic              direction_reg;

    logic [7:0]         mu_code;
    logic signed [15:0] mu_linear;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_mode_reg <= asfc_pkg::MODE_MULAW;
            direction_reg   <= asfc_pkg::DIR_ENCODE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                asfc_pkg::CFG_FORMAT_MODE: format_mode_reg <= cfg_data[1:0];
                asfc_pkg::CFG_DIRECTION:   direction_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_item_reg <= item;
        end
        if (in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    asfc_mulaw u_mulaw (
        .linear     (in_item_reg.linear_in),
        .code       (in_item_reg.code_in),
        .enc_code   (mu_code),
        .dec_linear (mu_linear)
    );

    always_comb
    begin
        result_next.code_out      = 8'd0;
        result_next.linear_out    = 16'sd0;
        result_next.block_end_out = in_item_reg.block_end;
        case (format_mode_reg)
            asfc_pkg::MODE_MULAW:
            begin
                if (direction_reg == asfc_pkg::DIR_ENCODE)
                begin
                    result_next.code_out = mu_code;
                end
                else
                begin
                    result_next.linear_out = mu_linear;
                end
            end
            asfc_pkg::MODE_EIGHT:
            begin
                if (direction_reg == asfc_pkg::DIR_ENCODE)
                begin
                    result_next.code_out = in_item_reg.linear_in[15:8] ^ asfc_pkg::EIGHT_FLIP;
                end
                else
                begin
                    result_next.linear_out =
                        {in_item_reg.code_in, 8'd0} - asfc_pkg::EIGHT_OFFSET;
                end
            end
            asfc_pkg::MODE_PASS:
            begin
                result_next.linear_out = in_item_reg.linear_in;
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/asfc_mulaw.sv
module asfc_mulaw (
    input  logic signed [15:0] linear,
    input  logic [7:0]         code,
    output logic [7:0]         enc_code,
    output logic signed [15:0] dec_linear
);

    logic [16:0] mag;
    logic [14:0] biased;
    logic [12:0] sat;
    logic [2:0]  expo;
    logic [12:0] shifted;
    logic [3:0]  mant;

    logic [7:0]  u;
    logic [7:0]  base;
    logic [14:0] dec_shift;
    logic [14:0] dec_mag;

    // encode: magnitude, bias, saturate, leading-one search over bits 12..5
    always_comb
    begin
        if (linear[15])
        begin
            mag = 17'd0 - {linear[15], linear};
        end
        else
        begin
            mag = {1'b0, linear};
        end
        biased = mag[16:2] + asfc_pkg::MU_BIAS;
        if (biased > {2'b00, asfc_pkg::MU_MAX})
        begin
            sat = asfc_pkg::MU_MAX;
        end
        else
        begin
            sat = biased[12:0];
        end
        expo = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (sat[i+5])
            begin
                expo = 3'(i);
            end
        end
        shifted  = sat >> ({1'b0, expo} + 4'd1);
        mant     = shifted[3:0];
        enc_code = ~{linear[15], expo, mant};
    end

    // decode: G.711 expansion; the zero trap code maps onto code zero
    always_comb
    begin
        if (code == asfc_pkg::MU_ZERO_TRAP)
        begin
            u = 8'hFF;
        end
        else
        begin
            u = ~code;
        end
        base      = {1'b0, u[3:0], 3'b000} + asfc_pkg::MU_DEC_BIAS;
        dec_shift = {7'd0, base} << u[6:4];
        dec_mag   = dec_shift - {7'd0, asfc_pkg::MU_DEC_BIAS};
        if (u[7])
        begin
            dec_linear = 16'd0 - {1'b0, dec_mag};
        end
        else
        begin
            dec_linear = {1'b0, dec_mag};
        end
    end

endmodule

// File: rtl/asfc_checker.sv
module asfc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input asfc_pkg::req_t    item,
    input logic              done,
    input asfc_pkg::result_t result
);

    // every result traces back to an earlier accepted request
    a_done_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without a request");

    // an accepted request yields a result
    a_req_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) ##1 rst_n |=> done)
        else $error("request lost");

    a_block_end: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.block_end_out == $past(item.block_end, 2))
        else $error("block_end_out mismatch");

    // only one of the two output fields carries data
    a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.code_out == 8'd0 || result.linear_out == 16'sd0))
        else $error("both output fields nonzero");

endmodule

bind audio_sample_format_codec asfc_checker u_asfc_checker (.*);
